// ===== hw/rtl/mfs_pkg.sv =====
package mfs_pkg;

	localparam int MaxThreads = 16;

	localparam logic [15:0] AgingThresholdRst = 16'd1500;
	localparam logic [7:0]  AgingStepRst      = 8'd10;
	localparam logic [7:0]  PriorityCapRst    = 8'd149;
	localparam logic [7:0]  LevelOneFloorRst  = 8'd100;
	localparam logic [7:0]  LevelTwoFloorRst  = 8'd50;
	localparam logic [15:0] RoundRobinRst     = 16'd100;

	typedef enum logic [1:0] {
		REQ_INSERT   = 2'd0,
		REQ_DISPATCH = 2'd1,
		REQ_AGE      = 2'd2,
		REQ_YIELD    = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		CFG_AGING_THRESHOLD = 3'd0,
		CFG_AGING_STEP      = 3'd1,
		CFG_PRIORITY_CAP    = 3'd2,
		CFG_LEVEL_ONE_FLOOR = 3'd3,
		CFG_LEVEL_TWO_FLOOR = 3'd4,
		CFG_ROUND_ROBIN     = 3'd5
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [7:0]  thread_id;
		logic [7:0]  priority_req;
		logic [31:0] burst_estimate;
		logic [31:0] now_tick;
		logic [1:0]  current_level;
		logic [7:0]  current_id;
		logic signed [31:0] current_remaining;
		logic [31:0] current_run_start;
	} in_item_t;

	typedef struct packed {
		logic        grant_valid;
		logic [7:0]  grant_id;
		logic [1:0]  grant_level;
		logic [7:0]  grant_priority;
		logic        preempt;
		logic        yield_now;
		logic        table_full;
	} out_item_t;

	typedef struct packed {
		logic [15:0] aging_threshold;
		logic [7:0]  aging_step;
		logic [7:0]  priority_cap;
		logic [7:0]  level_one_floor;
		logic [7:0]  level_two_floor;
		logic [15:0] round_robin_quantum;
	} cfg_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic scan_start;
		logic scan_step;
		logic finish;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_last;
	} sts_t;

endpackage

// ===== hw/rtl/mfs_ctrl.sv =====
module mfs_ctrl
	import mfs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands; input is held off until the result beat leaves
	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					cmd.scan_start = 1'b1;
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_last) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				cmd.finish = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

`ifndef NO_ASSERTIONS
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> state_q == ST_IDLE)
		else $error("load outside idle");
	a_out_after_finish: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_valid)
		else $error("no result after finish");
	a_no_ready_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_step |-> !in_ready)
		else $error("ready during scan");
`endif

endmodule

// ===== hw/rtl/mfs_datapath.sv =====
module mfs_datapath
	import mfs_pkg::*;
#(
	parameter int MAX_THREADS = MaxThreads
)
(
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  in_item_t  in_item,
	input  cmd_t      cmd,
	output sts_t      sts,
	output out_item_t out_item
);

	localparam int IW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
	localparam logic [IW:0] LastIdx = (IW + 1)'(MAX_THREADS - 1);

	logic [MAX_THREADS-1:0] valid_q;
	logic [7:0]  thr_q   [MAX_THREADS];
	logic [7:0]  pri_q   [MAX_THREADS];
	logic [31:0] burst_q [MAX_THREADS];
	logic [31:0] stamp_q [MAX_THREADS];
	logic [31:0] arr_q   [MAX_THREADS];
	logic [31:0] arrival_counter_q;

	in_item_t  req_q;
	out_item_t res_q;
	logic [IW:0] idx_q;
	logic [IW-1:0] ix;

	// best candidate per level; each entry is compared only against the best of its own level
	logic        b_vld_q [3];
	logic [IW-1:0] b_idx_q [3];
	logic [7:0]  b_thr_q [3];
	logic [7:0]  b_pri_q [3];
	logic [31:0] b_burst_q [3];
	logic [31:0] b_age_q [3];

	// free slot search
	logic          free_vld_q;
	logic [IW-1:0] free_idx_q;

	// current entry, with aging applied when this is an aging pass
	logic [7:0]  e_pri;
	logic [8:0]  aged_sum;
	logic        do_age;
	logic [31:0] e_age;
	logic [1:0]  e_lvl;
	logic [1:0]  li;
	logic        better;

	assign ix = idx_q[IW-1:0];
	assign sts.scan_last = (idx_q == LastIdx);

	always_comb begin
		do_age = (req_q.req_type == REQ_AGE) && valid_q[ix]
			&& ((req_q.now_tick - stamp_q[ix]) >= {16'd0, cfg.aging_threshold});
		aged_sum = {1'b0, pri_q[ix]} + {1'b0, cfg.aging_step};
		if (do_age) begin
			e_pri = (aged_sum > {1'b0, cfg.priority_cap}) ? cfg.priority_cap
				: aged_sum[7:0];
		end else begin
			e_pri = pri_q[ix];
		end
		if (e_pri >= cfg.level_one_floor) begin
			e_lvl = 2'd1;
		end else if (e_pri >= cfg.level_two_floor) begin
			e_lvl = 2'd2;
		end else begin
			e_lvl = 2'd3;
		end
		li = e_lvl - 2'd1;
		e_age = arrival_counter_q - arr_q[ix];
		better = 1'b0;
		if (!b_vld_q[li]) begin
			better = 1'b1;
		end else begin
			case (e_lvl)
				2'd1: begin
					if (burst_q[ix] != b_burst_q[li]) begin
						better = burst_q[ix] < b_burst_q[li];
					end else if (thr_q[ix] != b_thr_q[li]) begin
						better = thr_q[ix] < b_thr_q[li];
					end else begin
						better = e_age > b_age_q[li];
					end
				end
				2'd2: begin
					if (e_pri != b_pri_q[li]) begin
						better = e_pri > b_pri_q[li];
					end else if (thr_q[ix] != b_thr_q[li]) begin
						better = thr_q[ix] < b_thr_q[li];
					end else begin
						better = e_age > b_age_q[li];
					end
				end
				default: begin
					better = e_age > b_age_q[li];
				end
			endcase
		end
	end

	// finish stage values
	logic [1:0]    g_li;
	logic          g_any;
	logic [32:0]   ran;
	logic signed [33:0] rem;
	logic signed [33:0] fb;
	logic          pre;

	always_comb begin
		g_any = 1'b1;
		if (b_vld_q[0]) begin
			g_li = 2'd0;
		end else if (b_vld_q[1]) begin
			g_li = 2'd1;
		end else begin
			g_li = 2'd2;
			g_any = b_vld_q[2];
		end
		ran = {1'b0, req_q.now_tick - req_q.current_run_start};
		rem = 34'(signed'(req_q.current_remaining)) - signed'({1'b0, ran});
		fb = signed'({2'b00, b_burst_q[0]});
		pre = 1'b0;
		if (b_vld_q[0] && req_q.current_level > 2'd1) begin
			pre = 1'b1;
		end
		if (b_vld_q[1] && req_q.current_level > 2'd2) begin
			pre = 1'b1;
		end
		if (req_q.current_level == 2'd1 && b_vld_q[0]) begin
			if (rem > fb) begin
				pre = 1'b1;
			end else if (rem == fb && req_q.current_id > b_thr_q[0]) begin
				pre = 1'b1;
			end
		end
	end

	// control registers of the datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			arrival_counter_q <= '0;
			idx_q <= '0;
			free_vld_q <= 1'b0;
			for (int l = 0; l < 3; l++) begin
				b_vld_q[l] <= 1'b0;
			end
		end else begin
			if (cmd.scan_start) begin
				idx_q <= '0;
				free_vld_q <= 1'b0;
				for (int l = 0; l < 3; l++) begin
					b_vld_q[l] <= 1'b0;
				end
			end else if (cmd.scan_step) begin
				idx_q <= idx_q + 1'b1;
				if (!valid_q[ix] && !free_vld_q) begin
					free_vld_q <= 1'b1;
				end
				if (valid_q[ix] && better) begin
					b_vld_q[li] <= 1'b1;
				end
			end
			if (cmd.finish) begin
				case (req_q.req_type)
					REQ_INSERT: begin
						if (free_vld_q) begin
							valid_q[free_idx_q] <= 1'b1;
							arrival_counter_q <= arrival_counter_q + 32'd1;
						end
					end
					REQ_DISPATCH: begin
						if (g_any) begin
							valid_q[b_idx_q[g_li]] <= 1'b0;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= in_item;
		end
		if (cmd.scan_step) begin
			if (!valid_q[ix] && !free_vld_q) begin
				free_idx_q <= ix;
			end
			if (valid_q[ix] && better) begin
				b_idx_q[li] <= ix;
				b_thr_q[li] <= thr_q[ix];
				b_pri_q[li] <= e_pri;
				b_burst_q[li] <= burst_q[ix];
				b_age_q[li] <= e_age;
			end
			if (do_age) begin
				pri_q[ix] <= e_pri;
				stamp_q[ix] <= req_q.now_tick;
			end
		end
		if (cmd.finish) begin
			res_q <= '0;
			case (req_q.req_type)
				REQ_INSERT: begin
					if (free_vld_q) begin
						thr_q[free_idx_q] <= req_q.thread_id;
						pri_q[free_idx_q] <= req_q.priority_req;
						burst_q[free_idx_q] <= req_q.burst_estimate;
						stamp_q[free_idx_q] <= req_q.now_tick;
						arr_q[free_idx_q] <= arrival_counter_q;
					end else begin
						res_q.table_full <= 1'b1;
					end
				end
				REQ_DISPATCH: begin
					if (g_any) begin
						res_q.grant_valid <= 1'b1;
						res_q.grant_id <= b_thr_q[g_li];
						res_q.grant_level <= g_li + 2'd1;
						res_q.grant_priority <= b_pri_q[g_li];
					end
				end
				REQ_AGE: begin
					res_q.preempt <= pre;
				end
				default: begin
					res_q.yield_now <= (req_q.current_level != 2'd1)
						&& (req_q.current_level != 2'd2)
						&& (ran[31:0] >= {16'd0, cfg.round_robin_quantum});
				end
			endcase
		end
	end

	assign out_item = res_q;

`ifndef NO_ASSERTIONS
	a_arrival_on_insert: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.finish |=> $stable(arrival_counter_q))
		else $error("arrival counter moved outside finish");
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_step |-> idx_q <= LastIdx)
		else $error("scan index out of range");
	a_table_change: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.finish |=> $stable(valid_q))
		else $error("table valid bits moved outside finish");
`endif

endmodule

// ===== hw/rtl/multilevel_feedback_scheduler_unit.sv =====
// an accepted request is loaded, scanned over every table entry, finished, then offered as a result beat
// no new request is taken until the previous result beat has been accepted
// the scan walks the table one entry a cycle through a single compare unit
// reset: asynchronous active low; table empty, arrival counter zero,
// configuration registers back to their reset values
module multilevel_feedback_scheduler_unit
	import mfs_pkg::*;
#(
	parameter int MAX_THREADS = MaxThreads
)
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [15:0] cfg_data
);

	cfg_t cfg_q;
	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.aging_threshold <= AgingThresholdRst;
			cfg_q.aging_step <= AgingStepRst;
			cfg_q.priority_cap <= PriorityCapRst;
			cfg_q.level_one_floor <= LevelOneFloorRst;
			cfg_q.level_two_floor <= LevelTwoFloorRst;
			cfg_q.round_robin_quantum <= RoundRobinRst;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_AGING_THRESHOLD: cfg_q.aging_threshold <= cfg_data;
				CFG_AGING_STEP:      cfg_q.aging_step <= cfg_data[7:0];
				CFG_PRIORITY_CAP:    cfg_q.priority_cap <= cfg_data[7:0];
				CFG_LEVEL_ONE_FLOOR: cfg_q.level_one_floor <= cfg_data[7:0];
				CFG_LEVEL_TWO_FLOOR: cfg_q.level_two_floor <= cfg_data[7:0];
				CFG_ROUND_ROBIN:     cfg_q.round_robin_quantum <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	mfs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	mfs_datapath #(
		.MAX_THREADS (MAX_THREADS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_item  (in_data),
		.cmd      (cmd),
		.sts      (sts),
		.out_item (out_data)
	);

`ifndef NO_ASSERTIONS
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid)
		else $error("input taken while result pending");
	a_accept_then_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second beat taken during scan");
`endif

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import mfs_pkg::*;

	localparam int NumSlots = 16;
	localparam int StallLimit = 20000;

	// scoreboard: ready-table predictor and queue of expected result beats
	class sched_scoreboard;
		cfg_t       cfg;
		bit         slot_used [NumSlots];
		logic [7:0] slot_id [NumSlots];
		logic [7:0] slot_prio [NumSlots];
		logic [31:0] slot_burst [NumSlots];
		logic [31:0] slot_stamp [NumSlots];
		logic [31:0] slot_arrival [NumSlots];
		logic [31:0] arrival_count;
		out_item_t  pending_results [$];
		int         mismatches;
		int         occupancy;

		function new();
			cfg.aging_threshold     = AgingThresholdRst;
			cfg.aging_step          = AgingStepRst;
			cfg.priority_cap        = PriorityCapRst;
			cfg.level_one_floor     = LevelOneFloorRst;
			cfg.level_two_floor     = LevelTwoFloorRst;
			cfg.round_robin_quantum = RoundRobinRst;
			foreach (slot_used[i]) slot_used[i] = 0;
			arrival_count = 0;
			mismatches = 0;
			occupancy = 0;
		endfunction

		function void write_reg(cfg_idx_t idx, logic [15:0] val);
			case (idx)
				CFG_AGING_THRESHOLD: cfg.aging_threshold = val;
				CFG_AGING_STEP:      cfg.aging_step = val[7:0];
				CFG_PRIORITY_CAP:    cfg.priority_cap = val[7:0];
				CFG_LEVEL_ONE_FLOOR: cfg.level_one_floor = val[7:0];
				CFG_LEVEL_TWO_FLOOR: cfg.level_two_floor = val[7:0];
				CFG_ROUND_ROBIN:     cfg.round_robin_quantum = val;
				default: ;
			endcase
		endfunction

		function logic [1:0] level_for(logic [7:0] p);
			if (p >= cfg.level_one_floor) return 2'd1;
			if (p >= cfg.level_two_floor) return 2'd2;
			return 2'd3;
		endfunction

		// true when slot a ranks ahead of slot b in the given level
		function bit ranks_ahead(int a, int b, logic [1:0] lvl);
			logic [31:0] age_a, age_b;
			age_a = arrival_count - slot_arrival[a];
			age_b = arrival_count - slot_arrival[b];
			if (lvl == 2'd1) begin
				if (slot_burst[a] != slot_burst[b]) return slot_burst[a] < slot_burst[b];
				if (slot_id[a] != slot_id[b]) return slot_id[a] < slot_id[b];
			end else if (lvl == 2'd2) begin
				if (slot_prio[a] != slot_prio[b]) return slot_prio[a] > slot_prio[b];
				if (slot_id[a] != slot_id[b]) return slot_id[a] < slot_id[b];
			end
			return age_a > age_b;
		endfunction

		function int front_of(logic [1:0] lvl);
			int best;
			best = -1;
			for (int i = 0; i < NumSlots; i++) begin
				if (!slot_used[i] || level_for(slot_prio[i]) != lvl) continue;
				if (best < 0 || ranks_ahead(i, best, lvl)) best = i;
			end
			return best;
		endfunction

		// note an accepted request beat and queue its expected result
		function void note_request(in_item_t rq);
			out_item_t res;
			logic [31:0] ran;
			logic [8:0] sum;
			longint rem;
			int slot, f1, f2, b;
			res = '0;
			ran = rq.now_tick - rq.current_run_start;
			case (req_t'(rq.req_type))
				REQ_INSERT: begin
					slot = -1;
					for (int i = 0; i < NumSlots; i++)
						if (!slot_used[i] && slot < 0) slot = i;
					if (slot < 0) res.table_full = 1'b1;
					else begin
						slot_used[slot] = 1;
						slot_id[slot] = rq.thread_id;
						slot_prio[slot] = rq.priority_req;
						slot_burst[slot] = rq.burst_estimate;
						slot_stamp[slot] = rq.now_tick;
						slot_arrival[slot] = arrival_count;
						arrival_count++;
						occupancy++;
					end
				end
				REQ_DISPATCH: begin
					for (int l = 1; l <= 3; l++) begin
						b = front_of(l[1:0]);
						if (b >= 0 && !res.grant_valid) begin
							res.grant_valid = 1'b1;
							res.grant_id = slot_id[b];
							res.grant_level = l[1:0];
							res.grant_priority = slot_prio[b];
							slot_used[b] = 0;
							occupancy--;
						end
					end
				end
				REQ_AGE: begin
					for (int i = 0; i < NumSlots; i++) begin
						if (!slot_used[i]) continue;
						if (rq.now_tick - slot_stamp[i] >= {16'd0, cfg.aging_threshold}) begin
							sum = slot_prio[i] + cfg.aging_step;
							slot_prio[i] = (sum > cfg.priority_cap) ? cfg.priority_cap : sum[7:0];
							slot_stamp[i] = rq.now_tick;
						end
					end
					f1 = front_of(2'd1);
					f2 = front_of(2'd2);
					if (f1 >= 0 && rq.current_level > 2'd1) res.preempt = 1'b1;
					if (f2 >= 0 && rq.current_level > 2'd2) res.preempt = 1'b1;
					if (rq.current_level == 2'd1 && f1 >= 0) begin
						rem = longint'(rq.current_remaining) - longint'({32'd0, ran});
						if (rem > longint'({32'd0, slot_burst[f1]})) res.preempt = 1'b1;
						else if (rem == longint'({32'd0, slot_burst[f1]})
							&& rq.current_id > slot_id[f1]) res.preempt = 1'b1;
					end
				end
				default: begin
					if (rq.current_level != 2'd1 && rq.current_level != 2'd2
						&& ran >= {16'd0, cfg.round_robin_quantum}) res.yield_now = 1'b1;
				end
			endcase
			pending_results.push_back(res);
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
			mismatches++;
		endtask

		// compare a result beat against the oldest expectation
		task check_result(out_item_t got);
			out_item_t want;
			if (pending_results.size() == 0) begin
				report("unexpected result beat", 32'd0, 32'd0);
				return;
			end
			want = pending_results.pop_front();
			if (got.grant_valid !== want.grant_valid) report("grant_valid", got.grant_valid, want.grant_valid);
			if (got.grant_id !== want.grant_id) report("grant_id", got.grant_id, want.grant_id);
			if (got.grant_level !== want.grant_level) report("grant_level", got.grant_level, want.grant_level);
			if (got.grant_priority !== want.grant_priority)
				report("grant_priority", got.grant_priority, want.grant_priority);
			if (got.preempt !== want.preempt) report("preempt", got.preempt, want.preempt);
			if (got.yield_now !== want.yield_now) report("yield_now", got.yield_now, want.yield_now);
			if (got.table_full !== want.table_full) report("table_full", got.table_full, want.table_full);
		endtask
	endclass

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	in_item_t   in_data;
	logic       out_valid;
	logic       out_ready;
	out_item_t  out_data;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [2:0] cfg_index;
	logic [15:0] cfg_data;

	sched_scoreboard sb;
	int  send_idle_pct;
	int  recv_stall_pct;
	int  quiet_cycles;
	logic [31:0] tick_now;

	multilevel_feedback_scheduler_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// result side: random stalls, checking and the stall watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) sb.check_result(out_data);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= StallLimit) begin
				$display("Verification failed");
				$finish;
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic send_request(in_item_t rq);
		while ($urandom_range(99) < send_idle_pct) @(posedge clk);
		in_valid <= 1'b1;
		in_data <= rq;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_request(rq);
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_register(cfg_idx_t idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.write_reg(idx, val);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// wait for every expected beat to be checked, then idle before returning
	task automatic drain();
		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic in_item_t make_request(req_t kind);
		in_item_t rq;
		rq.req_type = kind;
		rq.thread_id = $urandom_range(3) == 0 ? 8'($urandom_range(3)) : 8'($urandom);
		rq.priority_req = 8'($urandom_range(149));
		case ($urandom_range(3))
			0: rq.burst_estimate = $urandom_range(8);
			1: rq.burst_estimate = $urandom;
			2: rq.burst_estimate = 32'hffff_ffff - $urandom_range(3);
			default: rq.burst_estimate = $urandom_range(5000);
		endcase
		rq.now_tick = tick_now;
		rq.current_level = $urandom_range(9) == 0 ? 2'd0 : 2'($urandom_range(3, 1));
		rq.current_id = 8'($urandom);
		case ($urandom_range(2))
			0: rq.current_remaining = $urandom;
			1: rq.current_remaining = $urandom_range(6000);
			default: rq.current_remaining = 32'sh8000_0000 + $urandom_range(3);
		endcase
		rq.current_run_start = ($urandom_range(4) == 0) ? $urandom : tick_now - $urandom_range(300);
		return rq;
	endfunction

	task automatic random_phase(int count, int idle, int stall);
		in_item_t rq;
		req_t kind;
		int pick;
		send_idle_pct = idle;
		recv_stall_pct = stall;
		for (int n = 0; n < count; n++) begin
			tick_now += ($urandom_range(7) == 0) ? $urandom_range(3000) : $urandom_range(60);
			pick = $urandom_range(99);
			// bias inserts when fewer than 8 slots are used, dispatch when 8 or more are
			if (pick < (sb.occupancy < 8 ? 50 : 25)) kind = REQ_INSERT;
			else if (pick < 65) kind = REQ_DISPATCH;
			else if (pick < 85) kind = REQ_AGE;
			else kind = REQ_YIELD;
			rq = make_request(kind);
			send_request(rq);
		end
		drain();
	endtask

	initial begin
		in_item_t rq;
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_AGING_THRESHOLD;
		cfg_data = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		quiet_cycles = 0;
		tick_now = 32'hffff_fe00;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty dispatch, fill past full, duplicates, extremes
		rq = make_request(REQ_DISPATCH);
		send_request(rq);
		for (int i = 0; i < 17; i++) begin
			rq = make_request(REQ_INSERT);
			rq.thread_id = (i < 4) ? 8'd7 : ((i == 5) ? 8'hff : 8'($urandom));
			rq.priority_req = (i % 3 == 0) ? 8'd149 : ((i % 3 == 1) ? 8'd0 : 8'd50);
			rq.burst_estimate = (i < 4) ? 32'd5 : $urandom;
			send_request(rq);
		end
		tick_now += 2000;
		rq = make_request(REQ_AGE);
		rq.current_level = 2'd1;
		rq.current_remaining = 32'sh7fff_ffff;
		send_request(rq);
		rq = make_request(REQ_YIELD);
		rq.current_level = 2'd0;
		rq.current_run_start = tick_now - 100;
		send_request(rq);
		for (int i = 0; i < 4; i++) begin
			rq = make_request(REQ_DISPATCH);
			send_request(rq);
		end
		drain();

		random_phase(200, 0, 0);
		write_register(CFG_AGING_THRESHOLD, 16'd1);
		write_register(CFG_AGING_STEP, 16'd149);
		write_register(CFG_PRIORITY_CAP, 16'd0);
		write_register(CFG_LEVEL_ONE_FLOOR, 16'd0);
		write_register(CFG_LEVEL_TWO_FLOOR, 16'd149);
		write_register(CFG_ROUND_ROBIN, 16'd1);
		random_phase(150, 48, 0);
		write_register(CFG_AGING_THRESHOLD, 16'hffff);
		write_register(CFG_AGING_STEP, 16'd0);
		write_register(CFG_PRIORITY_CAP, 16'd149);
		write_register(CFG_LEVEL_ONE_FLOOR, 16'd149);
		write_register(CFG_LEVEL_TWO_FLOOR, 16'd0);
		write_register(CFG_ROUND_ROBIN, 16'hffff);
		random_phase(150, 0, 48);
		write_register(CFG_AGING_THRESHOLD, 16'd40);
		write_register(CFG_AGING_STEP, 16'd25);
		write_register(CFG_PRIORITY_CAP, 16'd90);
		write_register(CFG_LEVEL_ONE_FLOOR, 16'd60);
		write_register(CFG_LEVEL_TWO_FLOOR, 16'd120);
		write_register(CFG_ROUND_ROBIN, 16'd30);
		random_phase(150, 10, 10);
		write_register(CFG_AGING_THRESHOLD, 16'd1500);
		write_register(CFG_AGING_STEP, 16'd10);
		write_register(CFG_PRIORITY_CAP, 16'd149);
		write_register(CFG_LEVEL_ONE_FLOOR, 16'd100);
		write_register(CFG_LEVEL_TWO_FLOOR, 16'd50);
		write_register(CFG_ROUND_ROBIN, 16'd100);
		random_phase(180, 0, 0);

		if (sb.mismatches == 0 && sb.pending_results.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/mfs_pkg.sv
hw/rtl/mfs_ctrl.sv
hw/rtl/mfs_datapath.sv
hw/rtl/multilevel_feedback_scheduler_unit.sv
tb/tb.sv
